FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When a holds, c must hold in the same cycle; ignored while reset is active.
`define ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
        else $error("assertion failed");

// When a holds, c must hold in the next cycle; ignored while reset is active.
`define ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
        else $error("assertion failed");

// When a holds, c must hold in the next cycle; checked through reset as well.
`define ASSERT_NXT_ALL(lbl, clk, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("assertion failed");

`endif

FILE: src/sus_pkg.sv
// ----------------------------------------------------------------------------
// sus_pkg
// Types and constants shared by the sorted unique set modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sus_pkg;

    // Number of cells in the store and the width of the fill count.
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // Command codes of the input beat.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_DUMP   = 2'd3
    } t_cmd;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic do_insert;
        logic do_delete;
        logic do_clear;
        logic dump_start;
        logic emit;
    } t_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic dump_last;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

FILE: src/sus_ctrl.sv
// ----------------------------------------------------------------------------
// sus_ctrl
// Controller: accepts a command, sequences its update or its dump stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  sus_pkg::t_status     i_status,
    output sus_pkg::t_ctrl       o_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_APPLY = 3'b010,
        S_DUMP  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.capture = 1'b1;
                    n_state        = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_IDLE;
                case (i_status.cmd)
                    sus_pkg::CMD_INSERT: o_ctrl.do_insert = 1'b1;
                    sus_pkg::CMD_DELETE: o_ctrl.do_delete = 1'b1;
                    sus_pkg::CMD_CLEAR:  o_ctrl.do_clear  = 1'b1;
                    sus_pkg::CMD_DUMP: begin
                        o_ctrl.dump_start = 1'b1;
                        n_state           = S_DUMP;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DUMP: begin
                // One beat is loaded whenever the output register is free.
                if (!i_status.out_busy) begin
                    o_ctrl.emit = 1'b1;
                    if (i_status.empty || i_status.dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: src/sus_datapath.sv
// ----------------------------------------------------------------------------
// sus_datapath
// Cell chain of sorted entries with per-cell compare, shift and rotate,
// plus the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  sus_pkg::t_ctrl                         i_ctrl,
    output sus_pkg::t_status                       o_status,
    input  wire logic [1:0]                        i_cmd,
    input  wire logic signed [sus_pkg::DATA_W-1:0] i_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [sus_pkg::DATA_W-1:0]      o_item,
    output logic                                   o_set_empty,
    output logic                                   o_last
);

    localparam int CAP = sus_pkg::CAPACITY;
    localparam int CW  = sus_pkg::CNT_W;
    localparam int DW  = sus_pkg::DATA_W;

    logic signed [DW-1:0] r_entries [CAP];
    logic signed [DW-1:0] n_entries [CAP];
    logic [CAP-1:0]       r_lt;
    logic [CAP-1:0]       r_eq;
    logic signed [DW-1:0] r_value;
    sus_pkg::t_cmd        r_cmd;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_remain;
    logic                 r_out_valid;
    logic signed [DW-1:0] r_item;
    logic                 r_set_empty;
    logic                 r_last;

    logic present;
    logic full;
    logic empty;

    assign present = |r_eq;
    assign full    = (r_count == CW'(CAP));
    assign empty   = (r_count == '0);

    // Status towards the controller.
    always_comb begin
        o_status.cmd       = r_cmd;
        o_status.empty     = empty;
        o_status.dump_last = (r_remain == CW'(1));
        o_status.out_busy  = r_out_valid && !i_out_ready;
    end

    // Next value of every cell: each cell looks at itself and its two
    // neighbours, and in a dump the top held cell takes the head cell.
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            n_entries[i] = r_entries[i];
            if (i_ctrl.do_insert && !present && !full) begin
                if (!r_lt[i]) begin
                    if (i == 0) begin
                        n_entries[i] = r_value;
                    end else if (r_lt[(i + CAP - 1) % CAP]) begin
                        n_entries[i] = r_value;
                    end else begin
                        n_entries[i] = r_entries[(i + CAP - 1) % CAP];
                    end
                end
            end else if (i_ctrl.do_delete && present) begin
                if (!r_lt[i]) begin
                    n_entries[i] = r_entries[(i + 1) % CAP];
                end
            end else if (i_ctrl.emit && !empty) begin
                // Rotate the held values down by one; the head wraps to the top.
                if (CW'(i + 1) < r_count) begin
                    n_entries[i] = r_entries[(i + 1) % CAP];
                end else if (CW'(i + 1) == r_count) begin
                    n_entries[i] = r_entries[0];
                end
            end
        end
    end

    // Cell registers and captured compare flags.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAP; i++) begin
            r_entries[i] <= n_entries[i];
        end
        if (i_ctrl.capture) begin
            r_value <= i_value;
            r_cmd   <= sus_pkg::t_cmd'(i_cmd);
            for (int i = 0; i < CAP; i++) begin
                r_lt[i] <= (CW'(i) < r_count) && (r_entries[i] < i_value);
                r_eq[i] <= (CW'(i) < r_count) && (r_entries[i] == i_value);
            end
        end
    end

    // Fill count and dump counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_remain <= '0;
        end else begin
            if (i_ctrl.do_insert && !present && !full) begin
                r_count <= r_count + CW'(1);
            end else if (i_ctrl.do_delete && present) begin
                r_count <= r_count - CW'(1);
            end else if (i_ctrl.do_clear) begin
                r_count <= '0;
            end
            if (i_ctrl.dump_start) begin
                r_remain <= r_count;
            end else if (i_ctrl.emit && !empty) begin
                r_remain <= r_remain - CW'(1);
            end
        end
    end

    // Output register of the result channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_ctrl.emit) begin
            r_item      <= empty ? '0 : r_entries[0];
            r_set_empty <= empty;
            r_last      <= empty || (r_remain == CW'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_item      = r_item;
    assign o_set_empty = r_set_empty;
    assign o_last      = r_last;

endmodule

`default_nettype wire

FILE: src/sorted_unique_set_core.sv
// Insert, delete and clear: accept, then one parallel cell update.
// Dump: a start step, then count beats (one if empty), one per cycle unless stalled,
// from the output register; the cell chain rotates once per beat and ends restored.
// A new beat is taken only in the idle state, so one command is in work at a time.
// Synchronous active-low reset clears the fill count, controller and output valid;
// cell contents are not reset.
// ----------------------------------------------------------------------------
// sorted_unique_set_core
// Set of distinct signed 32-bit values held in ascending order in a cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_set_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_cmd,
    input  wire logic signed [sus_pkg::DATA_W-1:0] i_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [sus_pkg::DATA_W-1:0]      o_item,
    output logic                                   o_set_empty,
    output logic                                   o_last
);

    sus_pkg::t_ctrl   ctrl;
    sus_pkg::t_status status;

    // Controller.
    sus_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    // Datapath.
    sus_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_status    (status),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_item      (o_item),
        .o_set_empty (o_set_empty),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

FILE: src/sus_checker.sv
// ----------------------------------------------------------------------------
// sus_checker
// Port-level checks of the sorted unique set, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sus_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              i_in_ready,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic signed [sus_pkg::DATA_W-1:0] i_item,
    input wire logic                              i_set_empty,
    input wire logic                              i_last
);

    logic in_beat;
    logic out_stall;

    assign in_beat   = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    // A stalled result beat holds valid, its item and its last flag.
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(i_item) && $stable(i_last))

    // The empty indication is a single final beat carrying zero.
    `ASSERT_IMP(a_empty_beat, i_clk, i_rst_n, i_out_valid && i_set_empty, i_last && (i_item == '0))

    // A command is worked on before the next one is taken.
    `ASSERT_NXT(a_one_cmd, i_clk, i_rst_n, in_beat, !i_in_ready)

    // Reset leaves no result pending.
    `ASSERT_NXT_ALL(a_reset_out, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind sorted_unique_set_core sus_checker u_sus_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_item      (o_item),
    .i_set_empty (o_set_empty),
    .i_last      (o_last)
);

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted unique set core. A queue of commands,
// filled by the stimulus process, feeds a clocked driver. A clocked monitor
// compares every dump beat against a predicted set kept in the bench. Both
// handshakes are throttled at random, in phases.
// ----------------------------------------------------------------------------

module tb;

    // One command beat waiting to be offered to the block.
    typedef struct {
        sus_pkg::t_cmd              cmd;
        logic [sus_pkg::DATA_W-1:0] value;
    } t_cmd_beat;

    // One output beat that a dump is due to produce.
    typedef struct {
        logic signed [sus_pkg::DATA_W-1:0] item;
        logic                              set_empty;
        logic                              last;
    } t_dump_beat;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    logic [1:0]                        i_cmd       = sus_pkg::CMD_INSERT;
    logic signed [sus_pkg::DATA_W-1:0] i_value     = '0;
    logic                              i_out_ready = 1'b0;
    logic                              o_in_ready;
    logic                              o_out_valid;
    logic signed [sus_pkg::DATA_W-1:0] o_item;
    logic                              o_set_empty;
    logic                              o_last;

    sorted_unique_set_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_item      (o_item),
        .o_set_empty (o_set_empty),
        .o_last      (o_last)
    );

    t_cmd_beat  cmd_backlog[$];
    t_dump_beat dump_beats_due[$];
    t_cmd_beat  next_cmd;
    t_dump_beat due_beat;

    // Predicted contents of the set.
    logic signed [sus_pkg::DATA_W-1:0] set_vals [sus_pkg::CAPACITY];
    int                                set_size = 0;

    // Throttling and receiver hold-off control.
    int tx_idle_pct  = 15;
    int rx_idle_pct  = 51;
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;

    // Statistics.
    int errors      = 0;
    int cmds_sent   = 0;
    int beats_seen  = 0;
    int dumps_seen  = 0;
    int full_drops  = 0;
    int peak_size   = 0;

    // Small pool of values so that duplicates and deletes of held values happen.
    logic [sus_pkg::DATA_W-1:0] value_pool [12];

    // Clock.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void queue_cmd(sus_pkg::t_cmd c, logic [sus_pkg::DATA_W-1:0] v);
        t_cmd_beat b;
        b.cmd   = c;
        b.value = v;
        cmd_backlog.push_back(b);
    endfunction

    function automatic logic [sus_pkg::DATA_W-1:0] pick_value();
        if ($urandom_range(99) < 75) begin
            return value_pool[$urandom_range(11)];
        end
        return $urandom();
    endfunction

    // Applies one accepted command to the predicted set and queues the beats
    // that a dump must produce.
    task automatic apply_to_set(input sus_pkg::t_cmd c,
                                input logic signed [sus_pkg::DATA_W-1:0] v);
        int         pos;
        t_dump_beat b;
        case (c)
            sus_pkg::CMD_INSERT: begin
                if (set_size >= sus_pkg::CAPACITY) begin
                    full_drops++;
                end else begin
                    pos = 0;
                    while (pos < set_size && set_vals[pos] < v) pos++;
                    if (!(pos < set_size && set_vals[pos] == v)) begin
                        for (int i = set_size; i > pos; i--) set_vals[i] = set_vals[i-1];
                        set_vals[pos] = v;
                        set_size++;
                        if (set_size > peak_size) peak_size = set_size;
                    end
                end
            end
            sus_pkg::CMD_DELETE: begin
                pos = 0;
                while (pos < set_size && set_vals[pos] != v) pos++;
                if (pos < set_size) begin
                    for (int i = pos; i + 1 < set_size; i++) set_vals[i] = set_vals[i+1];
                    set_size--;
                end
            end
            sus_pkg::CMD_CLEAR: begin
                set_size = 0;
            end
            default: begin
                dumps_seen++;
                if (set_size == 0) begin
                    b.item      = '0;
                    b.set_empty = 1'b1;
                    b.last      = 1'b1;
                    dump_beats_due.push_back(b);
                end else begin
                    for (int k = 0; k < set_size; k++) begin
                        b.item      = set_vals[k];
                        b.set_empty = 1'b0;
                        b.last      = (k == set_size - 1);
                        dump_beats_due.push_back(b);
                    end
                end
            end
        endcase
    endtask

    // Driver: records each accepted beat and offers the next one from the backlog.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                apply_to_set(sus_pkg::t_cmd'(i_cmd), i_value);
                cmds_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    next_cmd = cmd_backlog.pop_front();
                    i_cmd      <= next_cmd.cmd;
                    i_value    <= next_cmd.value;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready, with long hold-offs on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= 300;
            i_out_ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: each output beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_seen++;
            if (dump_beats_due.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected beat: item %0d empty %0b last %0b",
                             o_item, o_set_empty, o_last);
                end
            end else begin
                due_beat = dump_beats_due.pop_front();
                if (o_item !== due_beat.item || o_set_empty !== due_beat.set_empty ||
                    o_last !== due_beat.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("beat mismatch: expected item %0d empty %0b last %0b,",
                                 due_beat.item, due_beat.set_empty, due_beat.last,
                                 " got item %0d empty %0b last %0b",
                                 o_item, o_set_empty, o_last);
                    end
                end
            end
        end
    end

    // Stimulus.
    initial begin
        logic [sus_pkg::DATA_W-1:0] v;
        int                         r;

        for (int i = 0; i < 12; i++) value_pool[i] = $urandom();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, duplicates, absent deletes, clear and the empty dump.
        queue_cmd(sus_pkg::CMD_DUMP,   32'h0000_0000);
        queue_cmd(sus_pkg::CMD_DELETE, 32'h0000_0005);
        queue_cmd(sus_pkg::CMD_INSERT, 32'h0000_0000);
        queue_cmd(sus_pkg::CMD_INSERT, 32'h7FFF_FFFF);
        queue_cmd(sus_pkg::CMD_INSERT, 32'h8000_0000);
        queue_cmd(sus_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        queue_cmd(sus_pkg::CMD_INSERT, 32'h0000_0001);
        queue_cmd(sus_pkg::CMD_INSERT, 32'h0000_0000);
        queue_cmd(sus_pkg::CMD_DUMP,   32'hFFFF_FFFF);
        queue_cmd(sus_pkg::CMD_DELETE, 32'h0000_0005);
        queue_cmd(sus_pkg::CMD_DELETE, 32'h8000_0000);
        queue_cmd(sus_pkg::CMD_DELETE, 32'h7FFF_FFFF);
        queue_cmd(sus_pkg::CMD_DUMP,   32'h1234_5678);
        queue_cmd(sus_pkg::CMD_INSERT, 32'h5555_5555);
        queue_cmd(sus_pkg::CMD_INSERT, 32'hAAAA_AAAA);
        queue_cmd(sus_pkg::CMD_DUMP,   32'h0000_0000);
        queue_cmd(sus_pkg::CMD_CLEAR,  32'hDEAD_BEEF);
        queue_cmd(sus_pkg::CMD_DUMP,   32'h0000_0000);
        queue_cmd(sus_pkg::CMD_INSERT, 32'h0000_0007);
        queue_cmd(sus_pkg::CMD_DUMP,   32'h7FFF_FFFF);
        queue_cmd(sus_pkg::CMD_DELETE, 32'h0000_0007);
        queue_cmd(sus_pkg::CMD_DUMP,   32'h8000_0000);
        while (cmd_backlog.size() != 0 || i_in_valid || dump_beats_due.size() != 0)
            @(negedge i_clk);

        // Fill past capacity with distinct values in scrambled order, then hold
        // the receiver off while full dumps stall the command side.
        for (int k = 0; k < sus_pkg::CAPACITY + 2; k++) begin
            v = $urandom();
            v[31:25] = 7'((k * 37) % 128);
            queue_cmd(sus_pkg::CMD_INSERT, v);
        end
        holds_asked++;
        queue_cmd(sus_pkg::CMD_DUMP,   $urandom());
        queue_cmd(sus_pkg::CMD_DUMP,   $urandom());
        queue_cmd(sus_pkg::CMD_INSERT, $urandom());
        queue_cmd(sus_pkg::CMD_DELETE, v);
        queue_cmd(sus_pkg::CMD_DUMP,   $urandom());
        queue_cmd(sus_pkg::CMD_CLEAR,  $urandom());
        while (cmd_backlog.size() != 0 || i_in_valid || dump_beats_due.size() != 0)
            @(negedge i_clk);

        // Random phases; the sender waits for the output to drain between them.
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 51 : 0;
            rx_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 15 : 0;
            for (int n = 0; n < 52; n++) begin
                if (n % 16 == 0) value_pool[$urandom_range(11)] = $urandom();
                r = $urandom_range(99);
                if (r < 45)      queue_cmd(sus_pkg::CMD_INSERT, pick_value());
                else if (r < 75) queue_cmd(sus_pkg::CMD_DELETE, pick_value());
                else if (r < 80) queue_cmd(sus_pkg::CMD_CLEAR,  $urandom());
                else             queue_cmd(sus_pkg::CMD_DUMP,   $urandom());
            end
            while (cmd_backlog.size() != 0 || i_in_valid || dump_beats_due.size() != 0)
                @(negedge i_clk);
        end

        // Let any stray beats show up before the verdict.
        repeat (40) @(posedge i_clk);
        if (dump_beats_due.size() != 0) begin
            errors += dump_beats_due.size();
            $display("%0d predicted beats never arrived", dump_beats_due.size());
        end

        $display("Sent %0d commands including %0d dumps; checked %0d output beats.",
                 cmds_sent, dumps_seen, beats_seen);
        $display("Set peaked at %0d values; %0d inserts were dropped on a full store.",
                 peak_size, full_drops);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
